FILE: rtl/audio_fade_out_envelope_defines.svh
// Assertion macros for the fade-out envelope block.
// No dependencies; included by the top level only.
`ifndef AUDIO_FADE_OUT_ENVELOPE_DEFINES_SVH
`define AUDIO_FADE_OUT_ENVELOPE_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset
`define AFE_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset
`define AFE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/afe_pkg.sv
// Shared types, constants and the exponential curve table for the fade-out block.
// No dependencies.
package afe_pkg;

   // widths of samples, gain, quotient, position, length and registers
   localparam int SAMPLE_W   = 16;
   localparam int GAIN_W     = 17;              // unsigned Q1.16
   localparam int QUO_W      = 16;              // k/N as Q0.16
   localparam int POS_W      = 32;
   localparam int LEN_W      = 24;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // curve table: depth is a power of two, index is the top bits of k/N
   localparam int CURVE_IDX_W       = 8;
   localparam int CURVE_TABLE_DEPTH = 1 << CURVE_IDX_W;

   localparam int DIV_CNT_W = $clog2(QUO_W);

   localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(65536);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_START  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FADE_LENGTH = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_MODE  = CSR_IDX_W'(2);

   // ln(20) in Q32
   localparam logic [63:0] LN20_Q32 = 64'd12866572142;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUB,
      S_CMP,
      S_DIV,
      S_LOOKUP,
      S_EXP,
      S_MUL_L,
      S_MUL_R,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_EXP,
      MUL_LEFT,
      MUL_RIGHT
   } mul_sel_type;

   typedef struct packed {
      logic        capture;
      logic        sub_step;
      logic        div_init;
      logic        div_step;
      logic        lookup;
      mul_sel_type mul_sel;
      logic        load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bypass;   // fading off or frame before the window
      logic after;    // frame at or past the end of the window
      logic curve;    // exponential curve selected
   } dp_status_type;

   // One entry of 0.05^(i/depth) in Q1.16, worked out at elaboration
   function automatic logic [GAIN_W-1:0] curve_entry(int unsigned i);
      logic [63:0]  y;
      logic [63:0]  x;
      logic [63:0]  term;
      logic [63:0]  pos;
      logic [63:0]  neg;
      logic [63:0]  e;
      logic [127:0] prod;
      y    = (64'(i) * LN20_Q32) / CURVE_TABLE_DEPTH;
      x    = y >> 2;
      term = 64'd1 << 32;
      pos  = term;
      neg  = 64'd0;
      for (int n = 1; n <= 20; n++) begin
         prod = 128'(term) * 128'(x);
         term = prod[95:32] / 64'(n);
         if (n % 2 == 1) neg = neg + term;
         else pos = pos + term;
      end
      e = (pos > neg) ? pos - neg : 64'd0;
      if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      // e^(-y/4) squared twice
      for (int sq = 0; sq < 2; sq++) begin
         prod = 128'(e) * 128'(e);
         e    = prod[95:32];
         if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
      end
      return GAIN_W'((e + 64'd32768) >> 16);
   endfunction

   function automatic logic [CURVE_TABLE_DEPTH*GAIN_W-1:0] build_curve_table();
      logic [CURVE_TABLE_DEPTH*GAIN_W-1:0] tab;
      tab = '0;
      for (int unsigned i = 0; i < CURVE_TABLE_DEPTH; i++)
         tab[i*GAIN_W +: GAIN_W] = curve_entry(i);
      return tab;
   endfunction

   localparam logic [CURVE_TABLE_DEPTH*GAIN_W-1:0] CURVE_TABLE = build_curve_table();

endpackage

FILE: rtl/afe_ctrl.sv
// Sequencer for the fade-out block: handshakes, step order, divider count.
// Depends on afe_pkg.
module afe_ctrl
   import afe_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   ctrl_state_type        state_ff, state_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_SUB;
         S_SUB:    state_in = S_CMP;
         S_CMP:    state_in = (status.bypass || status.after) ? S_DONE : S_DIV;
         S_DIV:    if (cnt_ff == DIV_CNT_W'(QUO_W - 1)) state_in = S_LOOKUP;
         S_LOOKUP: state_in = status.curve ? S_EXP : S_MUL_L;
         S_EXP:    state_in = S_MUL_L;
         S_MUL_L:  state_in = S_MUL_R;
         S_MUL_R:  state_in = S_DONE;
         S_DONE:   if (slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      cmd.mul_sel  = MUL_NONE;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_SUB:    cmd.sub_step = 1'b1;
         S_CMP:    cmd.div_init = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_LOOKUP: cmd.lookup   = 1'b1;
         S_EXP:    cmd.mul_sel  = MUL_EXP;
         S_MUL_L:  cmd.mul_sel  = MUL_LEFT;
         S_MUL_R:  cmd.mul_sel  = MUL_RIGHT;
         S_DONE:   cmd.load_rsp = slot_free;
         default:  cmd = '0;
      endcase
   end

   // divider bit count
   always_comb begin
      cnt_in = '0;
      if (state_ff == S_DIV) cnt_in = cnt_ff + DIV_CNT_W'(1);
   end

   // result slot occupancy
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/afe_datapath.sv
// Datapath of the fade-out block: registers, frame counter, radix-2 divider,
// curve table, shared multiplier and result register. Depends on afe_pkg.
module afe_datapath
   import afe_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  ctrl_cmd_type                cmd,
   output dp_status_type               status,
   input  logic                        csr_write,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data,
   input  logic signed [SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [SAMPLE_W-1:0]  req_right_sample,
   input  logic                        req_track_start,
   output logic signed [SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [SAMPLE_W-1:0]  rsp_right_out,
   output logic                        rsp_in_fade
);

   // configuration
   logic [POS_W-1:0] start_ff;
   logic [LEN_W-1:0] len_ff;
   logic             curve_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         len_ff   <= '0;
         curve_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_FADE_START:  start_ff <= csr_data;
            CSR_FADE_LENGTH: len_ff   <= csr_data[LEN_W-1:0];
            CSR_CURVE_MODE:  curve_ff <= csr_data[0];
            default:         ;
         endcase
      end
   end

   // frame counter, saturating at all ones
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [POS_W-1:0] p_ff, p_in;

   assign p_in   = req_track_start ? '0 : pos_ff;
   assign pos_in = (&p_in) ? p_in : p_in + POS_W'(1);

   always_ff @(posedge clock) begin
      if (reset) pos_ff <= '0;
      else if (cmd.capture) pos_ff <= pos_in;
   end

   // input capture: raw samples for bypass, magnitudes for scaling
   logic signed [SAMPLE_W-1:0] l_ff, r_ff;
   logic [SAMPLE_W:0]          mag_l_ff, mag_r_ff;
   logic                       neg_l_ff, neg_r_ff;

   function automatic logic [SAMPLE_W:0] magnitude(logic [SAMPLE_W-1:0] v);
      return v[SAMPLE_W-1] ? (SAMPLE_W+1)'(17'h10000 - {1'b0, v}) : {1'b0, v};
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         p_ff     <= p_in;
         l_ff     <= req_left_sample;
         r_ff     <= req_right_sample;
         mag_l_ff <= magnitude(req_left_sample);
         mag_r_ff <= magnitude(req_right_sample);
         neg_l_ff <= req_left_sample[SAMPLE_W-1];
         neg_r_ff <= req_right_sample[SAMPLE_W-1];
      end
   end

   // k = p - start, top bit is the borrow (frame before the window)
   logic [POS_W:0] diff_ff;

   always_ff @(posedge clock) begin
      if (cmd.sub_step) diff_ff <= {1'b0, p_ff} - {1'b0, start_ff};
   end

   assign status.bypass = (len_ff == '0) || diff_ff[POS_W];
   assign status.after  = diff_ff[POS_W-1:0] >= POS_W'(len_ff);
   assign status.curve  = curve_ff;

   // restoring divider: (k << 16) / N, one quotient bit a cycle
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [LEN_W:0]   rem2;
   logic             ge;

   assign rem2 = {rem_ff, 1'b0};
   assign ge   = rem2 >= {1'b0, len_ff};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (cmd.div_init) begin
         rem_in = diff_ff[LEN_W-1:0];
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = ge ? LEN_W'(rem2 - {1'b0, len_ff}) : rem2[LEN_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   // shared 17x17 multiplier, keeps bits [32:16]
   logic [GAIN_W-1:0]   g_ff, tab_ff;
   logic [GAIN_W-1:0]   mul_a;
   logic [2*GAIN_W-1:0] prod;
   logic [GAIN_W-1:0]   scaled;
   logic [CURVE_IDX_W-1:0] idx;

   assign idx = quo_ff[QUO_W-1 -: CURVE_IDX_W];

   always_comb begin
      case (cmd.mul_sel)
         MUL_EXP:   mul_a = tab_ff;
         MUL_LEFT:  mul_a = mag_l_ff;
         MUL_RIGHT: mul_a = mag_r_ff;
         default:   mul_a = '0;
      endcase
   end

   assign prod   = mul_a * g_ff;
   assign scaled = prod[2*GAIN_W-2:QUO_W];

   // sign restored after scaling, truncation toward zero
   function automatic logic [SAMPLE_W-1:0] signed_res(logic neg, logic [GAIN_W-1:0] r);
      return neg ? SAMPLE_W'(~r[SAMPLE_W-1:0] + SAMPLE_W'(1)) : r[SAMPLE_W-1:0];
   endfunction

   logic [SAMPLE_W-1:0] res_l_ff, res_r_ff;

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         g_ff   <= GAIN_ONE - GAIN_W'(quo_ff);
         tab_ff <= CURVE_TABLE[GAIN_W*int'(idx) +: GAIN_W];
      end else if (cmd.mul_sel == MUL_EXP) begin
         g_ff   <= scaled;
      end
      if (cmd.mul_sel == MUL_LEFT)  res_l_ff <= signed_res(neg_l_ff, scaled);
      if (cmd.mul_sel == MUL_RIGHT) res_r_ff <= signed_res(neg_r_ff, scaled);
   end

   // result register
   logic signed [SAMPLE_W-1:0] out_l_ff, out_r_ff;
   logic                       out_fade_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         out_fade_ff <= !status.bypass;
         if (status.bypass) begin
            out_l_ff <= l_ff;
            out_r_ff <= r_ff;
         end else if (status.after) begin
            out_l_ff <= '0;
            out_r_ff <= '0;
         end else begin
            out_l_ff <= res_l_ff;
            out_r_ff <= res_r_ff;
         end
      end
   end

   assign rsp_left_out  = out_l_ff;
   assign rsp_right_out = out_r_ff;
   assign rsp_in_fade   = out_fade_ff;

endmodule

FILE: rtl/audio_fade_out_envelope.sv
// Fade-out envelope for stereo 16-bit PCM frames. A frame that passes
// unchanged or lies past the fade window goes from the subtract and compare
// steps straight to the result; a frame inside the window also passes the
// restoring divider, which forms k/N one quotient bit per cycle, and one
// shared multiplier used for the curve gain (with the exponential curve only)
// and then each channel in turn. One frame is worked on at a
// time; the next frame is taken once the current result sits in the output
// register, even if that result has not yet been transferred. The curve
// table is a constant and needs no fill after reset. Configuration writes
// are always accepted and must only be issued while the block is idle.
// Top level: instantiates afe_ctrl and afe_datapath; uses afe_pkg and the
// assertion macros in audio_fade_out_envelope_defines.svh.
`include "audio_fade_out_envelope_defines.svh"

module audio_fade_out_envelope
   import afe_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   // frame input
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [SAMPLE_W-1:0]  req_left_sample,
   input  logic signed [SAMPLE_W-1:0]  req_right_sample,
   input  logic                        req_track_start,
   // frame output
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [SAMPLE_W-1:0]  rsp_left_out,
   output logic signed [SAMPLE_W-1:0]  rsp_right_out,
   output logic                        rsp_in_fade,
   // register writes
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_data
);

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   afe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   afe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_track_start  (req_track_start),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_in_fade      (rsp_in_fade)
   );

   // a transfer in makes the block busy for at least the next cycle
   `AFE_ASSERT_NEXT(a_busy_after_take, req_valid && req_ready, !req_ready, "ready after take")
   // loading the result register always presents a result
   `AFE_ASSERT_NEXT(a_load_shows, cmd.load_rsp, rsp_valid, "result not presented")
   // a result is never loaded in the cycle a frame is taken
   `AFE_ASSERT_SAME(a_no_load_on_take, req_valid && req_ready, !cmd.load_rsp, "load during take")

endmodule
